@@ rtl/largest_empty_square_finder_assert.svh @@
// Assertion macros used by the largest empty square finder top level.
`ifndef LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH
`define LARGEST_EMPTY_SQUARE_FINDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, off during reset.
`define LESF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define LESF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define LESF_ASSERT_NOW(label, ante, cons)
`define LESF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/lesf_pkg.sv @@
// Shared constants and types of the largest empty square finder.
`default_nettype none
package lesf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int VAL_W      = 11;
  localparam int WIDTH_W    = 11;
  localparam int ROW_W      = 16;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_CHAR = 2'd2;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET    = 11'd1;
  localparam logic [ROW_W-1:0]   HEIGHT_RESET   = 16'd1;
  localparam logic [CHAR_W-1:0]  OBSTACLE_RESET = 8'd111;

  // One cell on its way from the counters to the value stage.
  typedef struct packed {
    logic             blocked;
    logic             first;
    logic             row_end;
    logic             grid_end;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } cell_t;

  // Value stage status seen by the top level.
  typedef struct packed {
    logic busy;
    logic advance;
    logic grid_end;
  } core_status_t;

endpackage
`default_nettype wire

@@ rtl/lesf_line_ram.sv @@
// Line store: single write port, single registered read port.
`default_nettype none
module lesf_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lesf_scan_ctrl.sv @@
// Configuration registers, raster counters and the cell stage register.
`default_nettype none
module lesf_scan_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [lesf_pkg::CHAR_W-1:0]     cell_char_i,
  input  wire logic                            advance_i,
  output logic                                 accept_o,
  output logic [lesf_pkg::COL_W-1:0]           rd_addr_o,
  output logic                                 cell_valid_o,
  output lesf_pkg::cell_t                      cell_o
);
  import lesf_pkg::*;

  logic [WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]   height_q;
  logic [CHAR_W-1:0]  obst_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               cell_valid_q, cell_valid_d;
  cell_t              cell_q, cell_d;
  logic [WIDTH_W-1:0] eff_width;
  logic [ROW_W-1:0]   eff_height;
  logic               accept;

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      obst_q   <= OBSTACLE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GRID_WIDTH:    width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_GRID_HEIGHT:   height_q <= cfg_data_i[ROW_W-1:0];
        REG_OBSTACLE_CHAR: obst_q   <= cfg_data_i[CHAR_W-1:0];
        default:           ;
      endcase
    end
  end

  // Clamp the geometry
  always_comb begin
    eff_width = width_q;
    if (width_q == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_width = WIDTH_W'(MAX_WIDTH);
    end
    eff_height = (height_q == '0) ? ROW_W'(1) : height_q;
  end

  assign in_ready_o = !cell_valid_q || advance_i;
  assign accept     = in_valid_i && in_ready_o;
  assign accept_o   = accept;
  assign rd_addr_o  = col_q;

  // Classify the incoming cell and advance the raster counters
  always_comb begin
    cell_d.blocked  = (cell_char_i == obst_q);
    cell_d.first    = (row_q == '0) || (col_q == '0);
    cell_d.row_end  = ((WIDTH_W'(col_q) + WIDTH_W'(1)) >= eff_width);
    cell_d.grid_end = cell_d.row_end &&
                      (({1'b0, row_q} + 17'd1) >= {1'b0, eff_height});
    cell_d.col      = col_q;
    cell_d.row      = row_q;
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (cell_d.grid_end) begin
        col_d = '0;
        row_d = '0;
      end else if (cell_d.row_end) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
    if (accept) begin
      cell_valid_d = 1'b1;
    end else if (advance_i) begin
      cell_valid_d = 1'b0;
    end else begin
      cell_valid_d = cell_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      cell_valid_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      cell_valid_q <= cell_valid_d;
    end
  end

  // Hold the cell for the value stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q <= cell_d;
    end
  end

  assign cell_valid_o = cell_valid_q;
  assign cell_o       = cell_q;

endmodule
`default_nettype wire

@@ rtl/lesf_dp_core.sv @@
// Square value update, best-square tracking and the result register.
`default_nettype none
module lesf_dp_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cell_valid_i,
  input  wire lesf_pkg::cell_t             cell_i,
  input  wire logic                        accept_i,
  input  wire logic [lesf_pkg::COL_W-1:0]  rd_addr_i,
  input  wire logic [lesf_pkg::VAL_W-1:0]  rd_data_i,
  output logic                             we_o,
  output logic [lesf_pkg::COL_W-1:0]       waddr_o,
  output logic [lesf_pkg::VAL_W-1:0]       wdata_o,
  output logic                             advance_o,
  output lesf_pkg::core_status_t           status_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             found_o,
  output logic [lesf_pkg::ROW_W-1:0]       top_row_o,
  output logic [lesf_pkg::COL_W-1:0]       left_col_o,
  output logic [lesf_pkg::VAL_W-1:0]       side_o
);
  import lesf_pkg::*;

  logic [VAL_W-1:0] left_q, diag_q, best_size_q;
  logic [ROW_W-1:0] best_row_q;
  logic [COL_W-1:0] best_col_q;
  logic             fwd_q;
  logic [VAL_W-1:0] fwd_data_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] up, m1, m2, v;
  logic [VAL_W-1:0] size_n;
  logic [ROW_W-1:0] row_n;
  logic [COL_W-1:0] col_n;
  logic             advance, found_n;

  // Pick the up value, forwarded when the read raced a write
  assign up = fwd_q ? fwd_data_q : rd_data_i;

  // Square side ending at this cell
  always_comb begin
    m1 = (up < left_q) ? up : left_q;
    m2 = (m1 < diag_q) ? m1 : diag_q;
    if (cell_i.blocked) begin
      v = '0;
    end else if (cell_i.first) begin
      v = VAL_W'(1);
    end else begin
      v = m2 + VAL_W'(1);
    end
  end

  // First strictly larger square wins
  always_comb begin
    size_n = best_size_q;
    row_n  = best_row_q;
    col_n  = best_col_q;
    if (v > best_size_q) begin
      size_n = v;
      row_n  = cell_i.row + ROW_W'(1) - ROW_W'(v);
      col_n  = cell_i.col + COL_W'(1) - v[COL_W-1:0];
    end
    found_n = (size_n != '0);
  end

  // Stall only a grid-end cell facing a full result register
  assign advance   = cell_valid_i && !(cell_i.grid_end && out_valid_q && !out_ready_i);
  assign advance_o = advance;

  assign we_o    = advance;
  assign waddr_o = cell_i.col;
  assign wdata_o = v;

  // Running values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (advance) begin
      left_q <= cell_i.row_end ? '0 : v;
      diag_q <= cell_i.row_end ? '0 : up;
      if (cell_i.grid_end) begin
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        best_size_q <= size_n;
        best_row_q  <= row_n;
        best_col_q  <= col_n;
      end
    end
  end

  // Capture forwarding for the read issued with this transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept_i) begin
      fwd_q <= advance && (cell_i.col == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      fwd_data_q <= v;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && cell_i.grid_end) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (advance && cell_i.grid_end) begin
      found_o    <= found_n;
      top_row_o  <= found_n ? row_n : '0;
      left_col_o <= found_n ? col_n : '0;
      side_o     <= size_n;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.busy     = cell_valid_i;
  assign status_o.advance  = advance;
  assign status_o.grid_end = cell_i.grid_end;

endmodule
`default_nettype wire

@@ rtl/largest_empty_square_finder.sv @@
// Top level of the largest empty square finder.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata[7:0] cell_char
//  m_axis    out  m_axis_tvalid/tready      tuser found; tdata top_row, left_col, side
//  cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i register, cfg_data_i value
//
// One cell per cycle unless stalled: the line store read is issued with the transfer,
// the value is written back as the cell advances; a same-column overlap is forwarded.
// Result valid is registered as the last cell of a grid leaves the cell register.
// After reset the store is not cleared; counters and best square are zero.
// Input stalls only when a grid-end cell meets a result still not taken.
`default_nettype none
`include "largest_empty_square_finder_assert.svh"
module largest_empty_square_finder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [7:0] cell_char
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [15:0] top_row, [25:16] left_col, [36:26] side, [39:37] zero
  output logic [lesf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                                 m_axis_tuser   // [0] found
);
  import lesf_pkg::*;

  logic             accept, advance, cell_valid;
  logic [COL_W-1:0] rd_addr, waddr;
  logic [VAL_W-1:0] rd_data, wdata;
  logic             we;
  cell_t            scan_cell;
  core_status_t     status;
  logic [ROW_W-1:0] top_row;
  logic [COL_W-1:0] left_col;
  logic [VAL_W-1:0] side;

  lesf_scan_ctrl u_scan (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cell_char_i  (s_axis_tdata),
    .advance_i    (advance),
    .accept_o     (accept),
    .rd_addr_o    (rd_addr),
    .cell_valid_o (cell_valid),
    .cell_o       (scan_cell)
  );

  lesf_line_ram #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (VAL_W)
  ) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  lesf_dp_core u_core (
    .clk_i,
    .rst_ni,
    .cell_valid_i (cell_valid),
    .cell_i       (scan_cell),
    .accept_i     (accept),
    .rd_addr_i    (rd_addr),
    .rd_data_i    (rd_data),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .advance_o    (advance),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .found_o      (m_axis_tuser),
    .top_row_o    (top_row),
    .left_col_o   (left_col),
    .side_o       (side)
  );

  // Pack the result fields
  assign m_axis_tdata = {3'b000, side, left_col, top_row};

  // Input backs up only behind a stalled grid-end cell
  `LESF_ASSERT_NOW(a_stall_cause, !s_axis_tready, status.busy && !status.advance && status.grid_end)
  // A new result comes only from a grid-end cell
  `LESF_ASSERT_NEXT(a_result_src, !m_axis_tvalid && !(status.advance && status.grid_end), !m_axis_tvalid)
  // No empty cell means a zero side
  `LESF_ASSERT_NOW(a_empty_side, m_axis_tvalid && !m_axis_tuser, side == '0)

endmodule
`default_nettype wire

@@ tb/sv/largest_empty_square_finder_checker.sv @@
// Channel monitor and result predictor for the largest empty square finder.
module largest_empty_square_finder_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lesf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lesf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            cell_valid_i,
  input  logic                            cell_ready_i,
  input  logic [7:0]                      cell_data_i,
  input  logic                            square_valid_i,
  input  logic                            square_ready_i,
  input  logic [lesf_pkg::OUT_DATA_W-1:0] square_data_i,
  input  logic                            square_found_i,
  output int                              pending_o,
  output int                              mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        found;
    logic [15:0] top_row;
    logic [9:0]  left_col;
    logic [10:0] side;
  } square_t;

  // Predictor copy of the registers
  logic [10:0] width_reg;
  logic [15:0] height_reg;
  logic [7:0]  obstacle_reg;

  // Predictor copy of the dynamic programming state
  logic [10:0] prev_row_sides [lesf_pkg::MAX_WIDTH];
  logic [10:0] left_side;
  logic [10:0] diag_side;
  logic [15:0] row_idx;
  logic [9:0]  col_idx;
  logic [10:0] best_side;
  logic [15:0] best_top;
  logic [9:0]  best_left;

  square_t expected_squares [$];
  int      mismatch_count;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: square result mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic restart_grid();
    left_side = '0;
    diag_side = '0;
    row_idx   = '0;
    col_idx   = '0;
    best_side = '0;
    best_top  = '0;
    best_left = '0;
  endtask

  // Compare one result transfer against the oldest expected square
  task automatic compare_result();
    square_t want;
    if (expected_squares.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending, tdata %h tuser %b",
                                square_data_i, square_found_i));
    end else begin
      want = expected_squares.pop_front();
      compare_field("found", square_found_i, want.found);
      compare_field("top_row", square_data_i[15:0], want.top_row);
      compare_field("left_col", square_data_i[25:16], want.left_col);
      compare_field("side", square_data_i[36:26], want.side);
      compare_field("padding", square_data_i[39:37], 0);
    end
  endtask

  task automatic apply_reg(input logic [lesf_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [lesf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      lesf_pkg::REG_GRID_WIDTH:    width_reg    = data[10:0];
      lesf_pkg::REG_GRID_HEIGHT:   height_reg   = data[15:0];
      lesf_pkg::REG_OBSTACLE_CHAR: obstacle_reg = data[7:0];
      default: ;
    endcase
  endtask

  // Advance the square recurrence by one cell; queue a result at grid end
  task automatic advance_square_dp(input logic [7:0] ch);
    int          eff_w;
    int          eff_h;
    int          col;
    logic [10:0] up;
    logic [10:0] side;
    logic [10:0] low;
    logic        row_end;
    logic        grid_end;
    square_t     res;
    eff_w = (width_reg == 0) ? 1 :
            ((width_reg > lesf_pkg::MAX_WIDTH) ? lesf_pkg::MAX_WIDTH : int'(width_reg));
    eff_h = (height_reg == 0) ? 1 : int'(height_reg);
    col   = int'(col_idx);
    up    = prev_row_sides[col];

    if (ch == obstacle_reg) begin
      side = '0;
    end else if (row_idx == 0 || col == 0) begin
      side = 11'd1;
    end else begin
      low = up;
      if (left_side < low) low = left_side;
      if (diag_side < low) low = diag_side;
      side = low + 11'd1;
    end

    diag_side           = up;
    left_side           = side;
    prev_row_sides[col] = side;

    // Only a strictly larger square replaces the best one
    if (side > best_side) begin
      best_side = side;
      best_top  = row_idx + 16'd1 - 16'(side);
      best_left = 10'(col_idx + 11'd1 - side);
    end

    row_end  = (col + 1 >= eff_w);
    grid_end = row_end && (int'(row_idx) + 1 >= eff_h);

    if (grid_end) begin
      res.found    = (best_side != 0);
      res.top_row  = res.found ? best_top : '0;
      res.left_col = res.found ? best_left : '0;
      res.side     = best_side;
      expected_squares.push_back(res);
      restart_grid();
    end else if (row_end) begin
      col_idx   = '0;
      row_idx   = row_idx + 16'd1;
      left_side = '0;
      diag_side = '0;
    end else begin
      col_idx = col_idx + 10'd1;
    end
  endtask

  // Watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg    = lesf_pkg::WIDTH_RESET;
      height_reg   = lesf_pkg::HEIGHT_RESET;
      obstacle_reg = lesf_pkg::OBSTACLE_RESET;
      restart_grid();
      expected_squares.delete();
      pending_o <= 0;
    end else begin
      if (square_valid_i && square_ready_i) compare_result();
      if (cfg_valid_i && cfg_ready_i) apply_reg(cfg_index_i, cfg_data_i);
      if (cell_valid_i && cell_ready_i) advance_square_dp(cell_data_i);
      pending_o <= expected_squares.size();
    end
  end

  initial mismatch_count = 0;

endmodule

@@ tb/sv/largest_empty_square_finder_test.sv @@
// Stimulus, pacing and verdict for the largest empty square finder.
module largest_empty_square_finder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lesf_pkg::*;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int SMALL_CELLS = 1150;
  localparam int PRESS_CELLS = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 13;

  localparam logic [7:0] OPEN_CELL  = 8'h2E;
  localparam logic [7:0] BLOCK_CELL = 8'h2A;

  // Three by three map: first side-two square at the top left, a tie later
  localparam logic [7:0] TIE_MAP [9] = '{
    OPEN_CELL,  OPEN_CELL, BLOCK_CELL,
    OPEN_CELL,  OPEN_CELL, OPEN_CELL,
    BLOCK_CELL, OPEN_CELL, OPEN_CELL
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic       cell_valid = 1'b0;
  logic       cell_ready;
  logic [7:0] cell_data  = '0;

  logic                  square_valid;
  logic                  square_ready = 1'b0;
  logic [OUT_DATA_W-1:0] square_data;
  logic                  square_found;

  int pending;
  int mismatches;

  // Pacing controls for sender and receiver
  logic steady    = 1'b0;
  logic hold_req  = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  // Effective geometry and obstacle as the block sees them
  int         cur_w    = 1;
  int         cur_h    = 1;
  logic [7:0] cur_obst = OBSTACLE_RESET;

  always #5 clk = ~clk;

  largest_empty_square_finder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (cell_valid),
    .s_axis_tready (cell_ready),
    .s_axis_tdata  (cell_data),
    .m_axis_tvalid (square_valid),
    .m_axis_tready (square_ready),
    .m_axis_tdata  (square_data),
    .m_axis_tuser  (square_found)
  );

  largest_empty_square_finder_checker square_monitor (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .cell_valid_i   (cell_valid),
    .cell_ready_i   (cell_ready),
    .cell_data_i    (cell_data),
    .square_valid_i (square_valid),
    .square_ready_i (square_ready),
    .square_data_i  (square_data),
    .square_found_i (square_found),
    .pending_o      (pending),
    .mismatches_o   (mismatches)
  );

  // Receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      square_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      square_ready <= 1'b0;
    end else begin
      square_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Stop a hung run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("largest_empty_square_finder verification failed");
    $finish;
  end

  function automatic logic [7:0] random_cell(input int blocked_pct);
    if ($urandom_range(99) < blocked_pct) return cur_obst;
    return 8'($urandom_range(255));
  endfunction

  // Register write; call only while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_WIDTH: begin
        cur_w = int'(data[10:0]);
        if (cur_w == 0) cur_w = 1;
        if (cur_w > MAX_WIDTH) cur_w = MAX_WIDTH;
      end
      REG_GRID_HEIGHT: begin
        cur_h = int'(data);
        if (cur_h == 0) cur_h = 1;
      end
      REG_OBSTACLE_CHAR: cur_obst = data[7:0];
      default: ;
    endcase
  endtask

  // Offer one cell, with random idle cycles ahead of it; return on its transfer
  task automatic push_cell(input logic [7:0] ch);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cell_valid <= 1'b0;
      @(negedge clk);
    end
    cell_valid <= 1'b1;
    cell_data  <= ch;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every pending result, then cover the result latency
  task automatic drain_results();
    @(negedge clk);
    cell_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_grid(input int blocked_pct);
    repeat (cur_w * cur_h) push_cell(random_cell(blocked_pct));
  endtask

  initial begin : stimulus
    int small_cells;
    int pct;
    int pick;
    int w;
    int h;
    int k;
    small_cells = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry: one blocked cell, then one empty cell
    push_cell(OBSTACLE_RESET);
    push_cell(8'h00);
    drain_results();
    small_cells += 2;

    // Zero width and height behave as one; obstacle at the low extreme
    write_reg(REG_GRID_WIDTH, 16'h0000);
    write_reg(REG_GRID_HEIGHT, 16'h0000);
    write_reg(REG_OBSTACLE_CHAR, 16'h0000);
    push_cell(8'h00);
    push_cell(8'hFF);
    drain_results();
    small_cells += 2;

    // Tie on the side: the first square must stay
    write_reg(REG_GRID_WIDTH, 16'd3);
    write_reg(REG_GRID_HEIGHT, 16'd3);
    write_reg(REG_OBSTACLE_CHAR, 16'(BLOCK_CELL));
    for (int i = 0; i < 9; i++) push_cell(TIE_MAP[i]);
    drain_results();
    small_cells += 9;

    // Fully open and fully blocked two by two grids
    write_reg(REG_GRID_WIDTH, 16'd2);
    write_reg(REG_GRID_HEIGHT, 16'd2);
    repeat (4) push_cell(OPEN_CELL);
    repeat (4) push_cell(BLOCK_CELL);
    small_cells += 8;

    // Many tiny grids while the receiver holds off
    drain_results();
    write_reg(REG_GRID_WIDTH, 16'd2);
    write_reg(REG_GRID_HEIGHT, 16'd1);
    hold_req <= 1'b1;
    repeat (PRESS_CELLS) push_cell(random_cell(50));
    small_cells += PRESS_CELLS;

    // Tall grid, one column wide; upper width bits are ignored
    drain_results();
    write_reg(REG_GRID_WIDTH, 16'hF801);
    write_reg(REG_GRID_HEIGHT, 16'd24);
    k = $urandom_range(cur_h - 1);
    for (int r = 0; r < cur_h; r++) push_cell(r < k ? cur_obst : random_cell(50));
    small_cells += cur_h;

    // Random small grids, leaving room for one full-width row
    while (small_cells < SMALL_CELLS - MAX_WIDTH) begin
      if ($urandom_range(99) < 40) begin
        drain_results();
        if ($urandom_range(99) < 50) begin
          pick = $urandom_range(99);
          w = (pick < 5) ? 0 : ((pick < 75) ? $urandom_range(8, 1) : $urandom_range(40, 9));
          write_reg(REG_GRID_WIDTH, {5'($urandom), 11'(w)});
        end
        if ($urandom_range(99) < 50) begin
          h = ($urandom_range(99) < 5) ? 0 : $urandom_range(8, 1);
          write_reg(REG_GRID_HEIGHT, 16'(h));
        end
        if ($urandom_range(99) < 50) begin
          write_reg(REG_OBSTACLE_CHAR, 16'($urandom));
        end
      end
      case ($urandom_range(4))
        0:       pct = 0;
        1:       pct = 10;
        2:       pct = 30;
        3:       pct = 60;
        default: pct = 100;
      endcase
      send_grid(pct);
      small_cells += cur_w * cur_h;
    end

    // Width above the maximum clamps; one full row with no idling on either side
    drain_results();
    write_reg(REG_GRID_WIDTH, 16'hFFFF);
    write_reg(REG_GRID_HEIGHT, 16'd1);
    steady <= 1'b1;
    k = $urandom_range(MAX_WIDTH - 1);
    for (int c = 0; c < cur_w; c++) push_cell(c < k ? cur_obst : random_cell(30));

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("largest_empty_square_finder verification clean");
    end else begin
      $display("largest_empty_square_finder verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lesf_pkg.sv
rtl/lesf_line_ram.sv
rtl/lesf_scan_ctrl.sv
rtl/lesf_dp_core.sv
rtl/largest_empty_square_finder.sv
tb/sv/largest_empty_square_finder_checker.sv
tb/sv/largest_empty_square_finder_test.sv
